// File: rtl/dfs_pkg.sv
package dfs_pkg;

  // widths fixed by the item fields
  localparam int unsigned POS_W  = 10;
  localparam int unsigned LEN_W  = 4;
  localparam int unsigned DATA_W = 64;
  localparam int unsigned IDX_W  = 2;

  // configuration register indexes
  localparam logic [IDX_W-1:0] CFG_IDX_DELIM_LEN   = 2'd0;
  localparam logic [IDX_W-1:0] CFG_IDX_DELIM_BYTES = 2'd1;

  // configuration reset values: one byte, comma
  localparam logic [LEN_W-1:0]  DELIM_LEN_RST   = 4'd1;
  localparam logic [DATA_W-1:0] DELIM_BYTES_RST = 64'd44;

  // line ending characters
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_CR = 8'h0D;

  // saturation value of the field count
  localparam logic [POS_W-1:0] COUNT_MAX = 10'd1023;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NO_DELIM  = 2'd1,
    STAT_SATURATED = 2'd2
  } status_t;

  typedef struct packed {
    logic             is_summary;
    logic [POS_W-1:0] field_start;
    logic [POS_W-1:0] field_end;
    logic [POS_W-1:0] field_count;
    status_t          status;
  } result_t;

  // results produced by one item: slot 0 first, slot 1 only with slot 0
  typedef struct packed {
    logic    push0;
    logic    push1;
    result_t res0;
    result_t res1;
  } push_t;

endpackage

// File: rtl/dfs_core.sv
module dfs_core #(
  parameter int MAX_DELIM_BYTES = 8,
  parameter int MAX_LINE_BYTES  = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       item_acc,
  input  logic [7:0]                 line_byte,
  input  logic                       end_of_line,
  input  logic                       cfg_wr,
  input  logic [dfs_pkg::IDX_W-1:0]  cfg_index,
  input  logic [dfs_pkg::DATA_W-1:0] cfg_data,
  output dfs_pkg::push_t             push
);

  localparam int RB_BYTES = (MAX_DELIM_BYTES < 2) ? 2 : MAX_DELIM_BYTES;
  localparam int RB_W     = RB_BYTES * 8;
  localparam int POS_LIM  = (MAX_LINE_BYTES - 1 > 1023) ? 1023 : MAX_LINE_BYTES - 1;
  localparam logic [dfs_pkg::POS_W-1:0] LIM = dfs_pkg::POS_W'(POS_LIM);

  // configuration registers
  logic [dfs_pkg::LEN_W-1:0]  cfg_len_r;
  logic [dfs_pkg::DATA_W-1:0] cfg_bytes_r;

  // line state
  logic [RB_W-1:0]          recent_r, recent_nxt;
  logic [2:0]               skip_r, skip_nxt;
  logic [dfs_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [dfs_pkg::POS_W-1:0] cfs_r, cfs_nxt;
  logic [dfs_pkg::POS_W-1:0] fields_r, fields_nxt;
  logic                     ovf_r, ovf_nxt;

  logic [dfs_pkg::LEN_W-1:0] len_eff;
  logic [MAX_DELIM_BYTES:0]  hit;
  logic                      win_hit;
  logic [dfs_pkg::POS_W:0]   end_raw;
  logic [dfs_pkg::POS_W:0]   mstart_raw;
  logic                      clamp;
  logic [dfs_pkg::POS_W-1:0] end_pos;
  logic                      match;
  logic                      ovf_a, ovf_b, ovf_c;
  logic [dfs_pkg::POS_W-1:0] fields_a, fields_b;
  logic [dfs_pkg::POS_W-1:0] cfs_mid;
  logic [dfs_pkg::POS_W-1:0] trim_end;
  logic                      final_fld;
  dfs_pkg::result_t          match_res, final_res, summ_res;

  // effective delimiter length
  always_comb begin
    if (cfg_len_r > dfs_pkg::LEN_W'(MAX_DELIM_BYTES)) begin
      len_eff = dfs_pkg::LEN_W'(MAX_DELIM_BYTES);
    end else begin
      len_eff = cfg_len_r;
    end
  end

  assign recent_nxt = {recent_r[RB_W-9:0], line_byte};

  // parallel window compare for every delimiter length
  always_comb begin
    hit = '0;
    for (int l = 1; l <= MAX_DELIM_BYTES; l++) begin
      hit[l] = 1'b1;
      for (int i = 0; i < l; i++) begin
        if (recent_nxt[8*(l-1-i) +: 8] != cfg_bytes_r[8*i +: 8]) hit[l] = 1'b0;
      end
    end
  end

  always_comb begin
    win_hit = 1'b0;
    for (int l = 1; l <= MAX_DELIM_BYTES; l++) begin
      if (len_eff == dfs_pkg::LEN_W'(l)) win_hit = hit[l];
    end
  end

  // position advance with saturation
  assign end_raw    = {1'b0, pos_r} + 11'd1;
  assign clamp      = end_raw > {1'b0, LIM};
  assign end_pos    = clamp ? LIM : end_raw[dfs_pkg::POS_W-1:0];
  assign mstart_raw = end_raw - {7'd0, len_eff};
  assign ovf_a      = ovf_r | clamp;

  // delimiter match
  assign match = (len_eff != '0) && (skip_r == 3'd0) &&
                 (end_raw >= {7'd0, len_eff}) &&
                 (mstart_raw >= {1'b0, cfs_r}) && win_hit;

  // field count after a match
  always_comb begin
    ovf_b    = ovf_a;
    fields_a = fields_r;
    if (match) begin
      if (fields_r == dfs_pkg::COUNT_MAX) begin
        ovf_b = 1'b1;
      end else begin
        fields_a = fields_r + 10'd1;
      end
    end
  end

  assign cfs_mid = match ? end_pos : cfs_r;

  // trailing lf, crlf or cr dropped from the last field
  always_comb begin
    trim_end = end_pos;
    if (line_byte == dfs_pkg::CHAR_LF) begin
      trim_end = end_pos - 10'd1;
      if (trim_end != '0 && recent_r[7:0] == dfs_pkg::CHAR_CR) begin
        trim_end = end_pos - 10'd2;
      end
    end else if (line_byte == dfs_pkg::CHAR_CR) begin
      trim_end = end_pos - 10'd1;
    end
  end

  assign final_fld = (len_eff != '0) && (cfs_mid < trim_end);

  // field count after the final field
  always_comb begin
    ovf_c    = ovf_b;
    fields_b = fields_a;
    if (final_fld) begin
      if (fields_a == dfs_pkg::COUNT_MAX) begin
        ovf_c = 1'b1;
      end else begin
        fields_b = fields_a + 10'd1;
      end
    end
  end

  // result items
  always_comb begin
    match_res.is_summary  = 1'b0;
    match_res.field_start = cfs_r;
    match_res.field_end   = mstart_raw[dfs_pkg::POS_W-1:0];
    match_res.field_count = '0;
    match_res.status      = ovf_b ? dfs_pkg::STAT_SATURATED : dfs_pkg::STAT_OK;

    final_res.is_summary  = 1'b0;
    final_res.field_start = cfs_mid;
    final_res.field_end   = trim_end;
    final_res.field_count = '0;
    final_res.status      = ovf_c ? dfs_pkg::STAT_SATURATED : dfs_pkg::STAT_OK;

    summ_res.is_summary  = 1'b1;
    summ_res.field_start = '0;
    summ_res.field_end   = '0;
    if (len_eff == '0) begin
      summ_res.field_count = '0;
      summ_res.status      = dfs_pkg::STAT_NO_DELIM;
    end else begin
      summ_res.field_count = fields_b;
      summ_res.status      = ovf_c ? dfs_pkg::STAT_SATURATED : dfs_pkg::STAT_OK;
    end
  end

  // slot assignment
  always_comb begin
    push.push0 = 1'b0;
    push.push1 = 1'b0;
    push.res0  = summ_res;
    push.res1  = summ_res;
    if (item_acc) begin
      if (match) begin
        push.push0 = 1'b1;
        push.res0  = match_res;
        push.push1 = end_of_line;
      end else if (end_of_line) begin
        push.push0 = 1'b1;
        if (final_fld) begin
          push.res0  = final_res;
          push.push1 = 1'b1;
        end
      end
    end
  end

  // next line state
  always_comb begin
    if (match) begin
      skip_nxt = 3'(len_eff - 4'd1);
    end else if (skip_r != 3'd0) begin
      skip_nxt = skip_r - 3'd1;
    end else begin
      skip_nxt = skip_r;
    end
    pos_nxt    = end_pos;
    cfs_nxt    = cfs_mid;
    fields_nxt = fields_a;
    ovf_nxt    = ovf_b;
    if (end_of_line) begin
      skip_nxt   = 3'd0;
      pos_nxt    = '0;
      cfs_nxt    = '0;
      fields_nxt = '0;
      ovf_nxt    = 1'b0;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recent_r <= '0;
      skip_r   <= '0;
      pos_r    <= '0;
      cfs_r    <= '0;
      fields_r <= '0;
      ovf_r    <= 1'b0;
    end else if (item_acc) begin
      recent_r <= recent_nxt;
      skip_r   <= skip_nxt;
      pos_r    <= pos_nxt;
      cfs_r    <= cfs_nxt;
      fields_r <= fields_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_len_r   <= dfs_pkg::DELIM_LEN_RST;
      cfg_bytes_r <= dfs_pkg::DELIM_BYTES_RST;
    end else if (cfg_wr) begin
      if (cfg_index == dfs_pkg::CFG_IDX_DELIM_LEN) begin
        cfg_len_r <= cfg_data[dfs_pkg::LEN_W-1:0];
      end
      if (cfg_index == dfs_pkg::CFG_IDX_DELIM_BYTES) begin
        cfg_bytes_r <= cfg_data;
      end
    end
  end

`ifndef SYNTHESIS
  a_second_is_summary: assert property (@(posedge clk) disable iff (!rst_n)
    push.push1 |-> (push.push0 && push.res1.is_summary && !push.res0.is_summary))
    else $error("second result of an item is not the line summary");
  a_line_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (item_acc && end_of_line) |=> (pos_r == '0 && fields_r == '0 && cfs_r == '0))
    else $error("line state not cleared after end of line");
  a_skip_bound: assert property (@(posedge clk) disable iff (!rst_n)
    skip_r <= 3'(MAX_DELIM_BYTES - 1))
    else $error("skip count beyond delimiter length");
`endif

endmodule

// File: rtl/dfs_result_fifo.sv
module dfs_result_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  dfs_pkg::push_t   push,
  input  logic             pop,
  output logic             room2,
  output logic             not_empty,
  output dfs_pkg::result_t head
);

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  dfs_pkg::result_t mem_r [DEPTH];
  logic [PW-1:0]    head_r, head_nxt;
  logic [PW-1:0]    tail_r, tail_nxt;
  logic [PW-1:0]    tail_p1;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_pop;

  assign not_empty = count_r != '0;
  assign room2     = count_r <= CW'(DEPTH - 2);
  assign head      = mem_r[head_r];
  assign do_pop    = pop && not_empty;
  assign tail_p1   = tail_r + PW'(1);

  // pointer and fill count update
  always_comb begin
    head_nxt  = do_pop ? head_r + PW'(1) : head_r;
    tail_nxt  = tail_r + PW'(push.push0) + PW'(push.push1);
    count_nxt = count_r + CW'(push.push0) + CW'(push.push1) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // entry storage, up to two writes a cycle
  always_ff @(posedge clk) begin
    if (push.push0) begin
      mem_r[tail_r] <= push.res0;
    end
    if (push.push1) begin
      mem_r[tail_p1] <= push.res1;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("result queue overfilled");
  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.push0 |-> (count_r <= CW'(DEPTH - 2)))
    else $error("results pushed without room for two");
`endif

endmodule

// File: rtl/delimited_field_splitter.sv
// a result item is queued when its byte is accepted and reaches out_ from the queue head
// throughput: one byte item per cycle while in_ready is high; the window compare
// and the position update finish in that cycle, and results go to a four-entry queue
// a byte that ends a line can give two result items, drained one per cycle while
// out_ready is high; in_ready drops while the queue has fewer than two free entries
// reset: rst_n synchronous active low; clears line state and queue, delimiter back to comma
module delimited_field_splitter #(
  parameter int MAX_DELIM_BYTES = 8,
  parameter int MAX_LINE_BYTES  = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_line_byte,
  input  logic                       in_end_of_line,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_is_summary,
  output logic [dfs_pkg::POS_W-1:0]  out_field_start,
  output logic [dfs_pkg::POS_W-1:0]  out_field_end,
  output logic [dfs_pkg::POS_W-1:0]  out_field_count,
  output logic [1:0]                 out_status,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [dfs_pkg::IDX_W-1:0]  cfg_index,
  input  logic [dfs_pkg::DATA_W-1:0] cfg_data
);

  dfs_pkg::push_t   push;
  dfs_pkg::result_t head;
  logic             room2;
  logic             item_acc;

  assign cfg_ready = 1'b1;
  assign in_ready  = room2;
  assign item_acc  = in_valid && in_ready;

  // per-byte match and line bookkeeping
  dfs_core #(
    .MAX_DELIM_BYTES (MAX_DELIM_BYTES),
    .MAX_LINE_BYTES  (MAX_LINE_BYTES)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_acc    (item_acc),
    .line_byte   (in_line_byte),
    .end_of_line (in_end_of_line),
    .cfg_wr      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .push        (push)
  );

  // result queue
  dfs_result_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (out_ready),
    .room2     (room2),
    .not_empty (out_valid),
    .head      (head)
  );

  assign out_is_summary  = head.is_summary;
  assign out_field_start = head.field_start;
  assign out_field_end   = head.field_end;
  assign out_field_count = head.field_count;
  assign out_status      = head.status;

endmodule

// File: bench/testbench.sv
module testbench;

  localparam int unsigned POS_LIM      = 1023;
  localparam int          CYCLE_LIMIT  = 1000000;
  localparam int          RANDOM_ITEMS = 450;
  localparam int          LONG_LINE    = 1030;
  localparam int          LINES_PER_PHASE = 6;

  // register index with no register behind it
  localparam logic [dfs_pkg::IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_SEMI  = 8'h3B;
  localparam logic [7:0] CHAR_PIPE  = 8'h7C;
  localparam logic [7:0] CHAR_A     = 8'h61;
  localparam logic [7:0] CHAR_B     = 8'h62;
  localparam logic [7:0] CHAR_X     = 8'h78;

  // one step of the stimulus: a register write or a line byte
  typedef struct packed {
    logic                       is_cfg;
    logic [dfs_pkg::IDX_W-1:0]  idx;
    logic [dfs_pkg::DATA_W-1:0] data;
    logic                       eol;
    logic                       typed;
    logic [1:0]                 nres;
    dfs_pkg::result_t           r0;
    dfs_pkg::result_t           r1;
  } row_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [7:0]                 in_line_byte = 8'h00;
  logic                       in_end_of_line = 1'b0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic                       out_is_summary;
  logic [dfs_pkg::POS_W-1:0]  out_field_start;
  logic [dfs_pkg::POS_W-1:0]  out_field_end;
  logic [dfs_pkg::POS_W-1:0]  out_field_count;
  logic [1:0]                 out_status;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [dfs_pkg::IDX_W-1:0]  cfg_index = '0;
  logic [dfs_pkg::DATA_W-1:0] cfg_data = '0;

  // splitter shadow: registers and line state
  logic [dfs_pkg::LEN_W-1:0]  delim_len_reg = dfs_pkg::DELIM_LEN_RST;
  logic [dfs_pkg::DATA_W-1:0] delim_bytes_reg = dfs_pkg::DELIM_BYTES_RST;
  logic [63:0]       win_bytes = '0;
  int unsigned       skip_left = 0;
  int unsigned       line_pos = 0;
  int unsigned       open_start = 0;
  int unsigned       field_tally = 0;
  logic              sat_flag = 1'b0;

  dfs_pkg::result_t pending_results[$];
  row_t             dir_rows[$];
  dfs_pkg::result_t want;
  int      error_count = 0;
  int      cycle_count = 0;
  int      rand_items = 0;
  int      stall_left = 0;
  bit      calm = 1'b0;

  delimited_field_splitter i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_line_byte    (in_line_byte),
    .in_end_of_line  (in_end_of_line),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_is_summary  (out_is_summary),
    .out_field_start (out_field_start),
    .out_field_end   (out_field_end),
    .out_field_count (out_field_count),
    .out_status      (out_status),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic dfs_pkg::result_t field_res(input int unsigned s, input int unsigned e,
                                                 input dfs_pkg::status_t st);
    dfs_pkg::result_t r;
    r = '0;
    r.field_start = dfs_pkg::POS_W'(s);
    r.field_end = dfs_pkg::POS_W'(e);
    r.status = st;
    return r;
  endfunction

  function automatic dfs_pkg::result_t summary_res(input int unsigned cnt,
                                                   input dfs_pkg::status_t st);
    dfs_pkg::result_t r;
    r = '0;
    r.is_summary = 1'b1;
    r.field_count = dfs_pkg::POS_W'(cnt);
    r.status = st;
    return r;
  endfunction

  function automatic row_t byte_row(input logic [7:0] b, input logic eol);
    row_t row;
    row = '0;
    row.data = {56'd0, b};
    row.eol = eol;
    return row;
  endfunction

  function automatic row_t known_row(input logic [7:0] b, input logic eol, input int n,
                                     input dfs_pkg::result_t r0, input dfs_pkg::result_t r1);
    row_t row;
    row = byte_row(b, eol);
    row.typed = 1'b1;
    row.nres = 2'(n);
    row.r0 = r0;
    row.r1 = r1;
    return row;
  endfunction

  function automatic row_t cfg_row(input logic [dfs_pkg::IDX_W-1:0] idx,
                                   input logic [dfs_pkg::DATA_W-1:0] data);
    row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.data = data;
    return row;
  endfunction

  // delimiter length in use, lengths above eight clamp
  function automatic int unsigned eff_len();
    return (delim_len_reg > 4'd8) ? 8 : int'(delim_len_reg);
  endfunction

  function automatic dfs_pkg::status_t live_status();
    return sat_flag ? dfs_pkg::STAT_SATURATED : dfs_pkg::STAT_OK;
  endfunction

  function automatic void bump_tally();
    if (field_tally >= dfs_pkg::COUNT_MAX) sat_flag = 1'b1;
    else field_tally++;
  endfunction

  // advance the shadow by one byte, return the number of result items
  function automatic int split_step(input logic [7:0] b, input logic eol,
                                    output dfs_pkg::result_t r0,
                                    output dfs_pkg::result_t r1);
    int unsigned len, pos, fin, mstart, trim, i;
    int n;
    logic hit;
    dfs_pkg::result_t r[2];
    len = eff_len();
    pos = line_pos;
    fin = pos + 1;
    n = 0;
    r[0] = '0;
    r[1] = '0;
    if (fin > POS_LIM) begin
      fin = POS_LIM;
      sat_flag = 1'b1;
    end
    win_bytes = {win_bytes[55:0], b};

    // delimiter window: oldest byte against the first delimiter byte
    hit = (len > 0) && (skip_left == 0) && (pos + 1 >= len) && (pos + 1 - len >= open_start);
    if (hit) begin
      for (i = 0; i < len; i++) begin
        if (win_bytes[8*(len-1-i) +: 8] != delim_bytes_reg[8*i +: 8]) hit = 1'b0;
      end
    end
    if (hit) begin
      mstart = pos + 1 - len;
      if (mstart > POS_LIM) mstart = POS_LIM;
      bump_tally();
      r[n] = field_res(open_start, mstart, live_status());
      n++;
      open_start = fin;
      skip_left = (len - 1) & 7;
    end else if (skip_left > 0) begin
      skip_left--;
    end
    line_pos = fin;

    // line end: drop one trailing line break, close the open field, summarize
    if (eol) begin
      if (len == 0) begin
        r[n] = summary_res(0, dfs_pkg::STAT_NO_DELIM);
        n++;
      end else begin
        trim = fin;
        if (win_bytes[7:0] == dfs_pkg::CHAR_LF) begin
          trim--;
          if (trim > 0 && win_bytes[15:8] == dfs_pkg::CHAR_CR) trim--;
        end else if (win_bytes[7:0] == dfs_pkg::CHAR_CR) begin
          trim--;
        end
        if (open_start < trim && n < 2) begin
          bump_tally();
          r[n] = field_res(open_start, trim, live_status());
          n++;
        end
        r[n] = summary_res(field_tally, live_status());
        n++;
      end
      skip_left = 0;
      line_pos = 0;
      open_start = 0;
      field_tally = 0;
      sat_flag = 1'b0;
    end
    r0 = r[0];
    r1 = r[1];
    return n;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic logic [7:0] pick_delim_char();
    case ($urandom_range(0, 6))
      0: return CHAR_COMMA;
      1: return CHAR_SEMI;
      2: return CHAR_PIPE;
      3: return dfs_pkg::CHAR_CR;
      4: return dfs_pkg::CHAR_LF;
      5: return CHAR_A;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [63:0] alpha_word();
    logic [63:0] w;
    int i;
    for (i = 0; i < 8; i++) w[8*i +: 8] = pick_delim_char();
    return w;
  endfunction

  // line content biased toward delimiter bytes and line breaks
  function automatic logic [7:0] pick_line_char();
    int unsigned len;
    len = eff_len();
    case ($urandom_range(0, 9))
      0, 1, 2: return (len > 0) ? delim_bytes_reg[8*$urandom_range(0, len-1) +: 8]
                                : CHAR_COMMA;
      3, 4: return 8'($urandom_range(0, 255));
      5: return dfs_pkg::CHAR_CR;
      6: return dfs_pkg::CHAR_LF;
      default: return CHAR_A + 8'($urandom_range(0, 3));
    endcase
  endfunction

  task automatic idle_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic run_row(input row_t row);
    dfs_pkg::result_t p0, p1;
    int n, gap;
    if (row.is_cfg) begin
      // registers change only with nothing in flight
      idle_input();
      wait_drained();
      repeat (4) @(posedge clk);
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_index <= row.idx;
      cfg_data <= row.data;
      do @(posedge clk); while (!cfg_ready);
      if (row.idx == dfs_pkg::CFG_IDX_DELIM_LEN) begin
        delim_len_reg = row.data[dfs_pkg::LEN_W-1:0];
      end else if (row.idx == dfs_pkg::CFG_IDX_DELIM_BYTES) begin
        delim_bytes_reg = row.data;
      end
      @(negedge clk);
      cfg_valid <= 1'b0;
    end else begin
      gap = pick_gap();
      @(negedge clk);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_valid <= 1'b1;
      in_line_byte <= row.data[7:0];
      in_end_of_line <= row.eol;
      do @(posedge clk); while (!in_ready);
      n = split_step(row.data[7:0], row.eol, p0, p1);
      if (row.typed) begin
        n = row.nres;
        p0 = row.r0;
        p1 = row.r1;
      end
      if (n > 0) pending_results.push_back(p0);
      if (n > 1) pending_results.push_back(p1);
    end
  endtask

  // one well-formed line with random content, partial delimiters mixed in
  task automatic random_line(input int body);
    logic [7:0] chars_q[$];
    int unsigned len;
    int k, i;
    len = eff_len();
    while (chars_q.size() < body) begin
      case ($urandom_range(0, 5))
        0: for (i = 0; i < len; i++) chars_q.push_back(delim_bytes_reg[8*i +: 8]);
        1: begin
          k = (len > 1) ? $urandom_range(1, len - 1) : 0;
          for (i = 0; i < k; i++) chars_q.push_back(delim_bytes_reg[8*i +: 8]);
        end
        default: chars_q.push_back(pick_line_char());
      endcase
    end
    case ($urandom_range(0, 3))
      1: chars_q.push_back(dfs_pkg::CHAR_LF);
      2: chars_q.push_back(dfs_pkg::CHAR_CR);
      3: begin
        chars_q.push_back(dfs_pkg::CHAR_CR);
        chars_q.push_back(dfs_pkg::CHAR_LF);
      end
      default: ;
    endcase
    if (chars_q.size() == 0) chars_q.push_back(pick_line_char());
    for (i = 0; i < chars_q.size(); i++) begin
      run_row(byte_row(chars_q[i], i == chars_q.size() - 1));
      rand_items++;
    end
  endtask

  task automatic run_phase(input int p);
    logic [63:0] bytes_word, len_word;
    int unsigned len;
    int i;
    bytes_word = {$urandom, $urandom};
    case (p % 8)
      0: begin
        len = 1;
        bytes_word[7:0] = CHAR_COMMA;
      end
      1: begin
        len = 2;
        bytes_word[15:0] = {dfs_pkg::CHAR_LF, dfs_pkg::CHAR_CR};
      end
      2: begin
        len = 3;
        bytes_word = alpha_word();
      end
      3: begin
        len = 8;
        bytes_word = alpha_word();
      end
      4: begin
        len = 0;
        bytes_word = alpha_word();
      end
      5: begin
        len = $urandom_range(9, 15);
        bytes_word = alpha_word();
      end
      6: len = $urandom_range(1, 8);
      default: begin
        len = $urandom_range(1, 8);
        bytes_word = ((p / 8) % 2 == 1) ? '1 : '0;
      end
    endcase
    calm = (p % 3 == 2);
    len_word = {$urandom, $urandom};
    len_word[dfs_pkg::LEN_W-1:0] = dfs_pkg::LEN_W'(len);
    run_row(cfg_row(dfs_pkg::CFG_IDX_DELIM_BYTES, bytes_word));
    run_row(cfg_row(dfs_pkg::CFG_IDX_DELIM_LEN, len_word));
    for (i = 0; i < LINES_PER_PHASE; i++) begin
      random_line(($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12));
      // now and then hold off until the output side has caught up
      if ($urandom_range(0, 7) == 0) begin
        idle_input();
        wait_drained();
      end
    end
  endtask

  // output side stalls
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if (!calm && $urandom_range(0, 5) == 0) stall_left = pick_gap();
    end
  end

  // compare each result item with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected, got summary %0b start %0d end %0d",
                 $time, out_is_summary, out_field_start, out_field_end,
                 " count %0d status %0d", out_field_count, out_status);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_is_summary !== want.is_summary) begin
          $display("%0t: is_summary expected %0b, got %0b", $time, want.is_summary,
                   out_is_summary);
          error_count++;
        end
        if (out_field_start !== want.field_start) begin
          $display("%0t: field_start expected %0d, got %0d", $time, want.field_start,
                   out_field_start);
          error_count++;
        end
        if (out_field_end !== want.field_end) begin
          $display("%0t: field_end expected %0d, got %0d", $time, want.field_end,
                   out_field_end);
          error_count++;
        end
        if (out_field_count !== want.field_count) begin
          $display("%0t: field_count expected %0d, got %0d", $time, want.field_count,
                   out_field_count);
          error_count++;
        end
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d, got %0d", $time, want.status, out_status);
          error_count++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int phase_no;
    int i;

    // directed lines, comma delimiter after reset
    dir_rows.push_back(known_row(CHAR_A, 1'b0, 0, '0, '0));
    dir_rows.push_back(known_row(CHAR_COMMA, 1'b0, 1, field_res(0, 1, dfs_pkg::STAT_OK), '0));
    dir_rows.push_back(known_row(CHAR_COMMA, 1'b0, 1, field_res(2, 2, dfs_pkg::STAT_OK), '0));
    dir_rows.push_back(known_row(8'hFF, 1'b1, 2, field_res(3, 4, dfs_pkg::STAT_OK),
                                 summary_res(3, dfs_pkg::STAT_OK)));
    // bare carriage return line
    dir_rows.push_back(known_row(dfs_pkg::CHAR_CR, 1'b1, 1,
                                 summary_res(0, dfs_pkg::STAT_OK), '0));
    // crlf ending dropped
    dir_rows.push_back(known_row(CHAR_X, 1'b0, 0, '0, '0));
    dir_rows.push_back(known_row(dfs_pkg::CHAR_CR, 1'b0, 0, '0, '0));
    dir_rows.push_back(known_row(dfs_pkg::CHAR_LF, 1'b1, 2, field_res(0, 1, dfs_pkg::STAT_OK),
                                 summary_res(1, dfs_pkg::STAT_OK)));
    // delimiter on the last byte leaves no final field
    dir_rows.push_back(known_row(CHAR_COMMA, 1'b1, 2, field_res(0, 0, dfs_pkg::STAT_OK),
                                 summary_res(1, dfs_pkg::STAT_OK)));
    // empty delimiter
    dir_rows.push_back(cfg_row(dfs_pkg::CFG_IDX_DELIM_LEN, 64'd0));
    dir_rows.push_back(known_row(CHAR_COMMA, 1'b0, 0, '0, '0));
    dir_rows.push_back(known_row(CHAR_COMMA, 1'b1, 1,
                                 summary_res(0, dfs_pkg::STAT_NO_DELIM), '0));
    // cr lf as the delimiter, matched across the line ending
    dir_rows.push_back(cfg_row(dfs_pkg::CFG_IDX_DELIM_BYTES,
                               {48'd0, dfs_pkg::CHAR_LF, dfs_pkg::CHAR_CR}));
    dir_rows.push_back(cfg_row(dfs_pkg::CFG_IDX_DELIM_LEN, 64'd2));
    dir_rows.push_back(byte_row(CHAR_A, 1'b0));
    dir_rows.push_back(byte_row(dfs_pkg::CHAR_CR, 1'b0));
    dir_rows.push_back(byte_row(dfs_pkg::CHAR_LF, 1'b1));
    // no match may reach back into the previous line
    dir_rows.push_back(known_row(dfs_pkg::CHAR_CR, 1'b1, 1,
                                 summary_res(0, dfs_pkg::STAT_OK), '0));
    dir_rows.push_back(byte_row(dfs_pkg::CHAR_LF, 1'b0));
    dir_rows.push_back(byte_row(CHAR_B, 1'b1));
    // length change in the middle of a line
    dir_rows.push_back(byte_row(CHAR_A, 1'b0));
    dir_rows.push_back(cfg_row(dfs_pkg::CFG_IDX_DELIM_LEN, 64'd1));
    dir_rows.push_back(byte_row(dfs_pkg::CHAR_CR, 1'b0));
    dir_rows.push_back(byte_row(CHAR_B, 1'b1));
    // length above eight clamps, all-ones delimiter
    dir_rows.push_back(cfg_row(dfs_pkg::CFG_IDX_DELIM_BYTES, '1));
    dir_rows.push_back(cfg_row(dfs_pkg::CFG_IDX_DELIM_LEN, 64'd15));
    for (i = 0; i < 8; i++) dir_rows.push_back(byte_row(8'hFF, i == 7));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[k]) run_row(dir_rows[k]);

    run_row(cfg_row(CFG_IDX_UNUSED, {$urandom, $urandom}));

    // one long line of commas: positions and count both saturate
    run_row(cfg_row(dfs_pkg::CFG_IDX_DELIM_BYTES, dfs_pkg::DELIM_BYTES_RST));
    run_row(cfg_row(dfs_pkg::CFG_IDX_DELIM_LEN, 64'(dfs_pkg::DELIM_LEN_RST)));
    for (i = 0; i < LONG_LINE; i++) begin
      run_row(byte_row((i == LONG_LINE - 1) ? dfs_pkg::CHAR_LF : CHAR_COMMA,
                       i == LONG_LINE - 1));
    end

    phase_no = 0;
    while (rand_items < RANDOM_ITEMS) begin
      run_phase(phase_no);
      phase_no++;
    end

    idle_input();
    wait_drained();
    repeat (10) @(posedge clk);
    if (error_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

// File: delimited_field_splitter.f
rtl/dfs_pkg.sv
rtl/dfs_core.sv
rtl/dfs_result_fifo.sv
rtl/delimited_field_splitter.sv
bench/testbench.sv
